/* rtl/core/ardefr_pkg.sv */
// Shared types, codes and constants for the ar archive deframer.
package ardefr_pkg;

    localparam int ENTRY_COUNT_BITS = 16;
    localparam int SIZE_BITS        = 34;
    localparam int NAME_BYTES       = 16;
    localparam int NAME_LEN_BITS    = 5;
    localparam int NUM_BITS         = 16;
    localparam int HDR_POS_BITS     = 6;
    localparam int FIFO_DEPTH       = 3;

    localparam logic [HDR_POS_BITS-1:0] HDR_LAST  = HDR_POS_BITS'(59);
    localparam logic [HDR_POS_BITS-1:0] SIZE_FIRST = HDR_POS_BITS'(48);
    localparam logic [HDR_POS_BITS-1:0] SIZE_END   = HDR_POS_BITS'(58);
    localparam logic [HDR_POS_BITS-1:0] NAME_END   = HDR_POS_BITS'(NAME_BYTES);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_DATA      = 3'd1,
        KIND_BAD_MAGIC = 3'd2,
        KIND_TRUNCATED = 3'd3,
        KIND_OK        = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        PH_MAGIC  = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_PAD    = 5'b01000,
        PH_DRAIN  = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        DM_SKIP   = 3'b001,
        DM_DIGITS = 3'b010,
        DM_DONE   = 3'b100
    } digit_mode_t;

    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               payload_byte;
        logic                     last_in_entry;
        logic [NUM_BITS-1:0]      entry_number;
        logic [SIZE_BITS-1:0]     member_size;
        logic [NAME_LEN_BITS-1:0] name_length;
        logic [63:0]              name_head;
        logic [63:0]              name_tail;
        logic                     last_of_run;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                3'd0:    b = 8'h21;
                3'd1:    b = 8'h3C;
                3'd2:    b = 8'h61;
                3'd3:    b = 8'h72;
                3'd4:    b = 8'h63;
                3'd5:    b = 8'h68;
                3'd6:    b = 8'h3E;
                default: b = 8'h0A;
            endcase
            return b;
        end
    endfunction

    function automatic result_t make_result(
        input kind_t                       k,
        input logic [7:0]                  pay,
        input logic                        last,
        input logic [ENTRY_COUNT_BITS-1:0] num,
        input logic [SIZE_BITS-1:0]        size
    );
        result_t r;
        begin
            r               = '0;
            r.kind          = k;
            r.payload_byte  = pay;
            r.last_in_entry = last;
            r.entry_number  = NUM_BITS'(num);
            r.member_size   = size;
            return r;
        end
    endfunction

    function automatic logic [1:0] ptr_add(input logic [1:0] p, input logic [1:0] k);
        logic [2:0] s;
        begin
            s = {1'b0, p} + {1'b0, k};
            if (s >= 3'(FIFO_DEPTH))
                s = s - 3'(FIFO_DEPTH);
            return s[1:0];
        end
    endfunction

endpackage

/* rtl/core/ar_archive_deframer.sv */
// ar archive deframer: magic check, header decode and data pass-through.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | archive_byte, end_of_archive
//  out     | out_valid / out_ready| kind, payload_byte, last_in_entry,
//          |                      | entry_number, member_size, name_length,
//          |                      | name_head, name_tail, last_of_run
//
// One byte is taken per cycle while in_ready is high; its state update is a single
// pass and its results (zero, one or two) land in a three-entry result queue.
// in_ready is high while the queue holds at most one result, so a stream
// giving one result per byte flows at one byte per cycle when out_ready stays high.
// Results are registered in the queue; the outputs show its head combinationally.
// Reset returns to expecting the magic with an empty queue.
module ar_archive_deframer
    import ardefr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               archive_byte,
    input  logic                     end_of_archive,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               kind,
    output logic [7:0]               payload_byte,
    output logic                     last_in_entry,
    output logic [NUM_BITS-1:0]      entry_number,
    output logic [SIZE_BITS-1:0]     member_size,
    output logic [NAME_LEN_BITS-1:0] name_length,
    output logic [63:0]              name_head,
    output logic [63:0]              name_tail,
    output logic                     last_of_run
);

    phase_t                      phase_reg, phase_next;
    logic [HDR_POS_BITS-1:0]     hpos_reg, hpos_next;
    logic [7:0]                  name_reg [NAME_BYTES];
    logic [SIZE_BITS-1:0]        acc_reg, acc_next;
    digit_mode_t                 dmode_reg, dmode_next;
    logic [SIZE_BITS-1:0]        remain_reg, remain_next;
    logic                        pad_reg, pad_next;
    logic [ENTRY_COUNT_BITS-1:0] count_reg, count_next, count_inc;

    result_t                     fifo_reg [FIFO_DEPTH];
    logic [1:0]                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]                  fill_reg, fill_next;
    logic [1:0]                  wr0, wr1;

    logic                        fire, pop;
    result_t                     res0, res1;
    logic [1:0]                  n_res;

    logic                        is_digit;
    logic [SIZE_BITS-1:0]        digit_val, acc_times_ten;
    logic [NAME_LEN_BITS-1:0]    len_sp, len_trim;
    logic [63:0]                 head_trim, tail_trim;
    result_t                     hdr_res;

    assign fire      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign in_ready  = (fill_reg <= 2'd1);
    assign out_valid = (fill_reg != 2'd0);

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    assign is_digit      = (archive_byte >= CHAR_ZERO) && (archive_byte <= CHAR_NINE);
    assign digit_val     = SIZE_BITS'(archive_byte - CHAR_ZERO);
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);

    // trim trailing spaces, then one slash
    always_comb
    begin
        len_sp = '0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (name_reg[i] != CHAR_SPACE)
                len_sp = NAME_LEN_BITS'(i + 1);
        end
        len_trim = len_sp;
        if (len_sp != '0 && name_reg[4'(len_sp - 1'b1)] == CHAR_SLASH)
            len_trim = len_sp - 1'b1;
        head_trim = '0;
        tail_trim = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (NAME_LEN_BITS'(i) < len_trim)
                head_trim[8*i +: 8] = name_reg[i];
            if (NAME_LEN_BITS'(i + 8) < len_trim)
                tail_trim[8*i +: 8] = name_reg[i + 8];
        end
        hdr_res             = make_result(KIND_HEADER, 8'h00, 1'b0, count_reg, acc_reg);
        hdr_res.name_length = len_trim;
        hdr_res.name_head   = head_trim;
        hdr_res.name_tail   = tail_trim;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        acc_next    = acc_reg;
        dmode_next  = dmode_reg;
        remain_next = remain_reg;
        pad_next    = pad_reg;
        count_next  = count_reg;
        res0        = '0;
        res1        = '0;
        n_res       = 2'd0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (archive_byte != magic_byte(hpos_reg[2:0]))
                    begin
                        res0       = make_result(KIND_BAD_MAGIC, 8'h00, 1'b0, '0, '0);
                        n_res      = 2'd1;
                        phase_next = PH_DRAIN;
                    end
                    else if (hpos_reg[2:0] == 3'd7)
                    begin
                        phase_next = PH_HEADER;
                        hpos_next  = '0;
                        if (end_of_archive)
                        begin
                            res0  = make_result(KIND_OK, 8'h00, 1'b0, count_reg, '0);
                            n_res = 2'd1;
                        end
                    end
                    else
                    begin
                        hpos_next = {3'b000, hpos_reg[2:0]} + 1'b1;
                        if (end_of_archive)
                        begin
                            res0  = make_result(KIND_BAD_MAGIC, 8'h00, 1'b0, '0, '0);
                            n_res = 2'd1;
                        end
                    end
                end
                PH_HEADER:
                begin
                    if (hpos_reg == '0)
                    begin
                        acc_next   = '0;
                        dmode_next = DM_SKIP;
                    end
                    if (hpos_reg >= SIZE_FIRST && hpos_reg < SIZE_END)
                    begin
                        if (dmode_reg == DM_SKIP)
                        begin
                            if (is_digit)
                            begin
                                acc_next   = digit_val;
                                dmode_next = DM_DIGITS;
                            end
                            else if (archive_byte != CHAR_SPACE)
                                dmode_next = DM_DONE;
                        end
                        else if (dmode_reg == DM_DIGITS)
                        begin
                            if (is_digit)
                                acc_next = acc_times_ten + digit_val;
                            else
                                dmode_next = DM_DONE;
                        end
                    end
                    if (hpos_reg >= HDR_LAST)
                    begin
                        res0      = hdr_res;
                        n_res     = 2'd1;
                        hpos_next = '0;
                        if (acc_reg == '0)
                        begin
                            count_next = count_inc;
                            if (end_of_archive)
                            begin
                                res1  = make_result(KIND_OK, 8'h00, 1'b0, count_inc, '0);
                                n_res = 2'd2;
                            end
                        end
                        else
                        begin
                            remain_next = acc_reg;
                            pad_next    = acc_reg[0];
                            phase_next  = PH_DATA;
                            if (end_of_archive)
                            begin
                                res1  = make_result(KIND_TRUNCATED, 8'h00, 1'b0,
                                                    count_reg, acc_reg);
                                n_res = 2'd2;
                            end
                        end
                    end
                    else
                    begin
                        hpos_next = hpos_reg + 1'b1;
                        if (end_of_archive)
                        begin
                            res0  = make_result(KIND_OK, 8'h00, 1'b0, count_reg, '0);
                            n_res = 2'd1;
                        end
                    end
                end
                PH_DATA:
                begin
                    res0  = make_result(KIND_DATA, archive_byte,
                                        (remain_reg[SIZE_BITS-1:1] == '0),
                                        count_reg, acc_reg);
                    n_res = 2'd1;
                    if (remain_reg[SIZE_BITS-1:1] == '0)
                    begin
                        remain_next = '0;
                        count_next  = count_inc;
                        phase_next  = pad_reg ? PH_PAD : PH_HEADER;
                        if (end_of_archive)
                        begin
                            res1  = make_result(KIND_OK, 8'h00, 1'b0, count_inc, '0);
                            n_res = 2'd2;
                        end
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                        if (end_of_archive)
                        begin
                            res1  = make_result(KIND_TRUNCATED, 8'h00, 1'b0,
                                                count_reg, acc_reg);
                            n_res = 2'd2;
                        end
                    end
                end
                PH_PAD:
                begin
                    pad_next   = 1'b0;
                    phase_next = PH_HEADER;
                    hpos_next  = '0;
                    if (end_of_archive)
                    begin
                        res0  = make_result(KIND_OK, 8'h00, 1'b0, count_reg, '0);
                        n_res = 2'd1;
                    end
                end
                PH_DRAIN:
                begin
                    phase_next = PH_DRAIN;
                end
                default:
                begin
                    phase_next = PH_MAGIC;
                end
            endcase

            if (end_of_archive)
            begin
                phase_next  = PH_MAGIC;
                hpos_next   = '0;
                acc_next    = '0;
                dmode_next  = DM_SKIP;
                remain_next = '0;
                pad_next    = 1'b0;
                count_next  = '0;
            end

            if (n_res == 2'd2)
                res1.last_of_run = 1'b1;
            else
                res0.last_of_run = 1'b1;
        end

        wr0         = ptr_add(rd_ptr_reg, fill_reg);
        wr1         = ptr_add(wr0, 2'd1);
        rd_ptr_next = pop ? ptr_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
        fill_next   = fill_reg + n_res - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            hpos_reg   <= '0;
            acc_reg    <= '0;
            dmode_reg  <= DM_SKIP;
            remain_reg <= '0;
            pad_reg    <= 1'b0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            acc_reg    <= acc_next;
            dmode_reg  <= dmode_next;
            remain_reg <= remain_next;
            pad_reg    <= pad_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && phase_reg == PH_HEADER && hpos_reg < NAME_END)
            name_reg[hpos_reg[3:0]] <= archive_byte;
        if (n_res != 2'd0)
            fifo_reg[wr0] <= res0;
        if (n_res == 2'd2)
            fifo_reg[wr1] <= res1;
    end

    assign kind          = fifo_reg[rd_ptr_reg].kind;
    assign payload_byte  = fifo_reg[rd_ptr_reg].payload_byte;
    assign last_in_entry = fifo_reg[rd_ptr_reg].last_in_entry;
    assign entry_number  = fifo_reg[rd_ptr_reg].entry_number;
    assign member_size   = fifo_reg[rd_ptr_reg].member_size;
    assign name_length   = fifo_reg[rd_ptr_reg].name_length;
    assign name_head     = fifo_reg[rd_ptr_reg].name_head;
    assign name_tail     = fifo_reg[rd_ptr_reg].name_tail;
    assign last_of_run   = fifo_reg[rd_ptr_reg].last_of_run;

endmodule
